// ===== hw/rtl/hnn_pkg.sv =====
package hnn_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned NULL_MODE_W = 2;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 2;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

   localparam logic [NULL_MODE_W-1:0] NULL_KEEP    = 2'd0;
   localparam logic [NULL_MODE_W-1:0] NULL_DROP    = 2'd1;
   localparam logic [NULL_MODE_W-1:0] NULL_REPLACE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NULL_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWERCASE = 1'd1;

   // Position within the three-byte U+FFFD sequence
   typedef enum logic [1:0] {
      SEQ_FIRST  = 2'd0,
      SEQ_SECOND = 2'd1,
      SEQ_THIRD  = 2'd2
   } seq_type;

   typedef enum logic {
      KIND_BYTE,
      KIND_FFFD
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic [NULL_MODE_W-1:0] null_mode;
      logic                   lowercase_enable;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] fffd_byte(seq_type seq);
      logic [BYTE_W-1:0] b;
      unique case (seq)
         SEQ_FIRST:  b = 8'hEF;
         SEQ_SECOND: b = 8'hBF;
         SEQ_THIRD:  b = 8'hBD;
         default:    b = 8'hBD;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/hnn_req_if.sv =====
interface hnn_req_if
   import hnn_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/hnn_rsp_if.sv =====
interface hnn_rsp_if
   import hnn_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/html_input_newline_null_normalizer.sv =====
// An accepted byte is written into the queue and then loaded into the output register
// as its first output beat. Throughput: one input byte per cycle while the queue
// has room; a NUL replaced by U+FFFD holds the output register for three beats, so
// the queue takes one more byte and the input then stalls until the queue has room.
// Reset (synchronous, active high): clears the pending CR, the queue and the
// output register; null_mode returns to 2 and lowercase_enable to 0.
module html_input_newline_null_normalizer
   import hnn_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   hnn_req_if.sink                req_bus,
   hnn_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type   cfg_ff;
   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.null_mode        <= NULL_REPLACE;
         cfg_ff.lowercase_enable <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NULL_MODE: cfg_ff.null_mode        <= csr_wr_data[NULL_MODE_W-1:0];
            CSR_LOWERCASE: cfg_ff.lowercase_enable <= csr_wr_data[0];
            default:       cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   hnn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hnn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty)
   );

   hnn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== hw/rtl/hnn_front.sv =====
module hnn_front
   import hnn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hnn_req_if.sink    req_bus,
   input  cfg_type    cfg,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic pending_cr_ff;
   logic pending_cr_in;
   logic accept;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;

   always_comb begin
      pending_cr_in   = pending_cr_ff;
      push            = 1'b0;
      push_entry.kind = KIND_BYTE;
      push_entry.data = req_bus.in_byte;
      if (accept) begin
         pending_cr_in = 1'b0;
         priority if (req_bus.end_of_input) begin
            push = 1'b0;
         end else if (req_bus.in_byte == CH_CR) begin
            pending_cr_in   = 1'b1;
            push            = 1'b1;
            push_entry.data = CH_LF;
         end else if (req_bus.in_byte == CH_LF && pending_cr_ff) begin
            // drop LF of a CR LF pair
            push = 1'b0;
         end else if (req_bus.in_byte == CH_NUL) begin
            priority if (cfg.null_mode == NULL_KEEP) begin
               push = 1'b1;
            end else if (cfg.null_mode == NULL_DROP) begin
               push = 1'b0;
            end else begin
               push            = 1'b1;
               push_entry.kind = KIND_FFFD;
            end
         end else begin
            push = 1'b1;
            if (cfg.lowercase_enable && req_bus.in_byte >= CH_UPPER_A &&
                req_bus.in_byte <= CH_UPPER_Z) begin
               push_entry.data = req_bus.in_byte + CASE_OFFSET;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_cr_ff <= 1'b0;
      end else begin
         pending_cr_ff <= pending_cr_in;
      end
   end

endmodule

// ===== hw/rtl/hnn_queue.sv =====
module hnn_queue
   import hnn_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty
);

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/hnn_back.sv =====
module hnn_back
   import hnn_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      not_empty,
   output logic      pop,
   hnn_rsp_if.source rsp_bus
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              last_ff;
   logic              last_in;
   seq_type           seq_ff;
   seq_type           seq_in;
   logic              load;

   // output register free, or its beat is taken this cycle
   assign load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      seq_in   = seq_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = not_empty;
         if (not_empty) begin
            unique case (head.kind)
               KIND_BYTE: begin
                  byte_in = head.data;
                  last_in = 1'b1;
                  pop     = 1'b1;
               end
               KIND_FFFD: begin
                  byte_in = fffd_byte(seq_ff);
                  last_in = (seq_ff == SEQ_THIRD);
                  pop     = (seq_ff == SEQ_THIRD);
                  unique case (seq_ff)
                     SEQ_FIRST:  seq_in = SEQ_SECOND;
                     SEQ_SECOND: seq_in = SEQ_THIRD;
                     default:    seq_in = SEQ_FIRST;
                  endcase
               end
               default: begin
                  byte_in = head.data;
                  last_in = 1'b1;
                  pop     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seq_ff   <= SEQ_FIRST;
      end else begin
         valid_ff <= valid_in;
         seq_ff   <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.out_byte    = byte_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule

// ===== hw/rtl/hnn_checker.sv =====
module hnn_checker
   import hnn_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last_of_run
);

   // a stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_last_of_run))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // only the first two bytes of U+FFFD are not last of their run
   a_not_last_fffd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_out_byte == 8'hEF || rsp_out_byte == 8'hBF)
      else $error("non-final beat is not part of U+FFFD");

   a_no_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte != CH_CR)
      else $error("CR reached the output");

   // EF is always followed by BF in the next beat
   a_ef_then_bf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_byte == 8'hEF && !rsp_last_of_run
      |=> !rsp_valid || (rsp_out_byte == 8'hBF && !rsp_last_of_run))
      else $error("U+FFFD sequence broken");

endmodule

bind html_input_newline_null_normalizer hnn_checker u_hnn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_last_of_run (rsp_bus.last_of_run)
);

// ===== dv/tb_html_input_newline_null_normalizer.sv =====
`timescale 1ns / 1ps

module tb_html_input_newline_null_normalizer;
   import hnn_pkg::*;

   localparam logic [NULL_MODE_W-1:0] NULL_ALIAS  = 2'd3;
   localparam logic [BYTE_W-1:0]      REPL_BYTE0  = 8'hEF;
   localparam logic [BYTE_W-1:0]      REPL_BYTE1  = 8'hBF;
   localparam logic [BYTE_W-1:0]      REPL_BYTE2  = 8'hBD;
   localparam int                     SETTLE_CYCLES = 8;
   localparam int                     STREAM_PHASES = 6;
   localparam int                     PHASE_ITEMS   = 35;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } norm_beat_type;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   hnn_req_if req_if ();
   hnn_rsp_if rsp_if ();

   html_input_newline_null_normalizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow of the block's state and registers
   logic [NULL_MODE_W-1:0] null_handling;
   logic                   fold_case;
   logic                   cr_seen;
   norm_beat_type          normalized_beats[$];
   int                     mismatches = 0;
   int                     burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #500_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void push_beat(logic [BYTE_W-1:0] b, logic last);
      norm_beat_type beat;
      beat.out_byte    = b;
      beat.last_of_run = last;
      normalized_beats.push_back(beat);
   endfunction

   function automatic void normalize_byte(logic [BYTE_W-1:0] b, logic eoi);
      logic after_cr;
      after_cr = cr_seen;
      cr_seen  = 1'b0;
      if (eoi) begin
         return;
      end
      if (b == CH_CR) begin
         cr_seen = 1'b1;
         push_beat(CH_LF, 1'b1);
      end else if (b == CH_LF && after_cr) begin
         return;
      end else if (b == CH_NUL) begin
         if (null_handling == NULL_KEEP) begin
            push_beat(CH_NUL, 1'b1);
         end else if (null_handling != NULL_DROP) begin
            // replace and the unused fourth mode both emit U+FFFD
            push_beat(REPL_BYTE0, 1'b0);
            push_beat(REPL_BYTE1, 1'b0);
            push_beat(REPL_BYTE2, 1'b1);
         end
      end else if (fold_case && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
         push_beat(b + CASE_OFFSET, 1'b1);
      end else begin
         push_beat(b, 1'b1);
      end
   endfunction

   // Predict on accepted input beats, check accepted output beats
   always @(posedge clock) begin
      norm_beat_type want;
      if (reset) begin
         null_handling = NULL_REPLACE;
         fold_case     = 1'b0;
         cr_seen       = 1'b0;
         normalized_beats.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_NULL_MODE) begin
               null_handling = csr_wr_data[NULL_MODE_W-1:0];
            end else if (csr_index == CSR_LOWERCASE) begin
               fold_case = csr_wr_data[0];
            end
         end
         if (req_if.valid && req_if.ready) begin
            normalize_byte(req_if.in_byte, req_if.end_of_input);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (normalized_beats.size() == 0) begin
               $error("unexpected output beat: out_byte %02h last_of_run %0b",
                      rsp_if.out_byte, rsp_if.last_of_run);
               mismatches++;
            end else begin
               want = normalized_beats.pop_front();
               if (rsp_if.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_if.out_byte);
                  mismatches++;
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  $error("last_of_run mismatch: expected %0b, actual %0b",
                         want.last_of_run, rsp_if.last_of_run);
                  mismatches++;
               end
            end
         end
      end
   end

   // Receiver back-pressure in one of four randomly picked patterns
   always @(negedge clock) begin
      int unsigned stall_mode;
      int unsigned stall_count;
      if (stall_count % 40 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         2: rsp_if.ready <= (stall_count % 3 == 0);
         default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
      stall_count++;
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic eoi);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(0, 5);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.in_byte      <= b;
      req_if.end_of_input <= eoi;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      burst_left--;
   endtask

   // Hold off until every expected beat is out and the pipeline has settled
   task automatic drain();
      if (req_if.valid) begin
         req_if.valid <= 1'b0;
      end
      while (normalized_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_config(input logic [NULL_MODE_W-1:0] nm,
                             input logic [CSR_DATA_W-1:0] lc);
      write_csr(CSR_NULL_MODE, nm);
      write_csr(CSR_LOWERCASE, lc);
   endtask

   task automatic test_reset_defaults();
      send_item(CH_NUL, 1'b0);
      send_item(CH_UPPER_A, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_CR, 1'b0);
      // end of input clears the pending CR, so the LF passes
      send_item(CH_CR, 1'b1);
      send_item(CH_LF, 1'b0);
      drain();
   endtask

   task automatic test_null_modes();
      set_config(NULL_KEEP, 2'd0);
      send_item(CH_NUL, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_NUL, 1'b0);
      drain();
      set_config(NULL_DROP, 2'd0);
      send_item(CH_NUL, 1'b0);
      send_item(8'h01, 1'b0);
      drain();
      set_config(NULL_ALIAS, 2'd0);
      send_item(CH_NUL, 1'b0);
      drain();
      set_config(NULL_REPLACE, 2'd0);
      send_item(CH_NUL, 1'b0);
      drain();
   endtask

   task automatic test_lowercase();
      set_config(NULL_REPLACE, 2'd1);
      send_item(8'h40, 1'b0);
      send_item(CH_UPPER_A, 1'b0);
      send_item(CH_UPPER_Z, 1'b0);
      send_item(8'h5B, 1'b0);
      send_item(CH_NUL, 1'b0);
      drain();
      // only bit 0 of the write counts
      write_csr(CSR_LOWERCASE, 2'b10);
      send_item(CH_UPPER_Z, 1'b0);
      drain();
   endtask

   task automatic test_random_stream();
      logic [NULL_MODE_W-1:0] nm;
      logic [CSR_DATA_W-1:0]  lc;
      int unsigned            pick;
      for (int phase = 0; phase < STREAM_PHASES; phase++) begin
         case (phase)
            0: begin nm = NULL_KEEP;    lc = 2'd0; end
            1: begin nm = NULL_ALIAS;   lc = 2'd1; end
            2: begin nm = NULL_DROP;    lc = 2'd3; end
            3: begin nm = NULL_REPLACE; lc = 2'd0; end
            default: begin
               nm = NULL_MODE_W'($urandom_range(0, 3));
               lc = CSR_DATA_W'($urandom_range(0, 3));
            end
         endcase
         set_config(nm, lc);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               send_item(CH_CR, 1'b0);
            end else if (pick < 22) begin
               send_item(CH_CR, 1'b0);
               send_item(CH_LF, 1'b0);
               n++;
            end else if (pick < 32) begin
               send_item(CH_LF, 1'b0);
            end else if (pick < 42) begin
               send_item(CH_NUL, 1'b0);
            end else if (pick < 57) begin
               send_item(BYTE_W'($urandom_range(CH_UPPER_A - 1, CH_UPPER_Z + 1)), 1'b0);
            end else if (pick < 62) begin
               send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end else begin
               send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
         end
         drain();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.in_byte      = '0;
      req_if.end_of_input = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_null_modes();
      test_lowercase();
      test_random_stream();

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hnn_pkg.sv
hw/rtl/hnn_req_if.sv
hw/rtl/hnn_rsp_if.sv
hw/rtl/hnn_front.sv
hw/rtl/hnn_queue.sv
hw/rtl/hnn_back.sv
hw/rtl/html_input_newline_null_normalizer.sv
hw/rtl/hnn_checker.sv
dv/tb_html_input_newline_null_normalizer.sv
